@@ hw/rtl/mfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Meter frame receiver package
// Shared types and constants for the meter reply deframer.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam logic [7:0] StartByteA = 8'hFA;
  localparam logic [7:0] StartByteB = 8'hFB;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_VALID   = 2'd1,
    ST_BADSUM  = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] reading_bits;
  } mfr_result_t;

endpackage

@@ hw/rtl/mfr_deframer.sv @@
// ----------------------------------------------------------------------------
// Meter frame deframer
// Tracks the position in the 8-byte reply, captures the payload and forms
// the per-byte result from the current state and the incoming byte.
// ----------------------------------------------------------------------------
module mfr_deframer
  import mfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_en_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  device_address_i,
  output mfr_result_t result_o
);

  typedef enum logic [2:0] {
    POS_SYNC_A = 3'd0,
    POS_SYNC_B = 3'd1,
    POS_ADDR   = 3'd2,
    POS_PL0    = 3'd3,
    POS_PL1    = 3'd4,
    POS_PL2    = 3'd5,
    POS_PL3    = 3'd6,
    POS_SUM    = 3'd7
  } pos_e;

  pos_e       pos_q, pos_d;
  logic [7:0] payload_q [4];
  logic [7:0] payload_d [4];
  logic [7:0] sum;

  assign sum = payload_q[0] + payload_q[1] + payload_q[2] + payload_q[3];

  always_comb begin
    pos_d     = pos_q;
    payload_d = payload_q;
    result_o  = '{status: ST_PENDING, reading_bits: 32'd0};
    case (pos_q)
      POS_SYNC_A: begin
        if (rx_byte_i == StartByteA) pos_d = POS_SYNC_B;
      end
      POS_SYNC_B: begin
        pos_d = (rx_byte_i == StartByteB) ? POS_ADDR : POS_SYNC_A;
      end
      POS_ADDR: begin
        pos_d = (rx_byte_i == device_address_i) ? POS_PL0 : POS_SYNC_A;
      end
      POS_PL0: begin
        payload_d[0] = rx_byte_i;
        pos_d        = POS_PL1;
      end
      POS_PL1: begin
        payload_d[1] = rx_byte_i;
        pos_d        = POS_PL2;
      end
      POS_PL2: begin
        payload_d[2] = rx_byte_i;
        pos_d        = POS_PL3;
      end
      POS_PL3: begin
        payload_d[3] = rx_byte_i;
        pos_d        = POS_SUM;
      end
      POS_SUM: begin
        pos_d = POS_SYNC_A;
        if (sum == rx_byte_i) begin
          result_o.status       = ST_VALID;
          result_o.reading_bits = {payload_q[0], payload_q[1], payload_q[2], payload_q[3]};
        end else begin
          result_o.status = ST_BADSUM;
        end
      end
      default: pos_d = POS_SYNC_A;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_SYNC_A;
      payload_q <= '{default: 8'd0};
    end else if (byte_en_i) begin
      pos_q     <= pos_d;
      payload_q <= payload_d;
    end
  end

endmodule

@@ hw/rtl/meter_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// Meter frame receiver
// Deframes 8-byte meter replies from a received byte stream.
// ----------------------------------------------------------------------------
// Every byte transfer on the rx channel yields exactly one result transfer:
// pending, valid frame (with the 32-bit payload word, first payload byte in
// bits 31..24) or checksum error. The result of a byte is registered in the cycle
// after its acceptance, and a new byte can be accepted in every cycle, also
// while the previous result is being taken; the single result register is
// the only limit, so rx_ready_o drops only while a result is held unclaimed.
// The device address register should be written while no byte is in flight.
module meter_frame_receiver_unit
  import mfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] reading_bits_o
);

  logic        rx_fire;
  logic [7:0]  device_address_q;
  mfr_result_t result;
  mfr_result_t result_q;
  logic        res_valid_q;

  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_address_q <= 8'd0;
    end else if (cfg_we_i) begin
      device_address_q <= cfg_wdata_i;
    end
  end

  mfr_deframer u_deframer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .byte_en_i        (rx_fire),
    .rx_byte_i        (rx_byte_i),
    .device_address_i (device_address_q),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      res_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      result_q <= result;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign status_o       = result_q.status;
  assign reading_bits_o = result_q.reading_bits;

endmodule

@@ hw/rtl/mfr_checker.sv @@
// ----------------------------------------------------------------------------
// Meter frame receiver checker
// Port-level assertions for the meter frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module mfr_checker
  import mfr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_o,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] reading_bits_o
);

  // A held result keeps the output valid until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o)
    else $error("result dropped before transfer");

  // Each accepted byte gives a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_ready_o |=> res_valid_o)
    else $error("accepted byte produced no result");

  // With nothing held, the receiver must take a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_o |-> rx_ready_o)
    else $error("receiver stalled while output register empty");

  // Only the three defined status codes are ever shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (status_o == ST_PENDING || status_o == ST_VALID ||
                     status_o == ST_BADSUM))
    else $error("undefined status code");

  // The payload word is zero unless the frame is valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != ST_VALID |-> reading_bits_o == 32'd0)
    else $error("payload word shown without a valid frame");

endmodule

bind meter_frame_receiver_unit mfr_checker u_mfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rx_valid_i     (rx_valid_i),
  .rx_ready_o     (rx_ready_o),
  .res_valid_o    (res_valid_o),
  .res_ready_i    (res_ready_i),
  .status_o       (status_o),
  .reading_bits_o (reading_bits_o)
);
